>>> rtl/bitmap_page_allocator_macros.svh
// assertion helpers used by the rtl
`ifndef BITMAP_PAGE_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define BPA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bitmap page allocator check failed");

// next-cycle implication
`define BPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bitmap page allocator check failed");

`endif

>>> rtl/bpa_pkg.sv
package bpa_pkg;

    localparam int WORD_BITS  = 32;
    localparam int WORD_SHIFT = 5;
    localparam int ADDR_BITS  = 64;
    localparam int PC_BITS    = 13;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOPAGE  = 2'd1;
    localparam logic [1:0] ST_BADADDR = 2'd2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic REG_BASE  = 1'b0;
    localparam logic REG_PAGES = 1'b1;

    localparam logic [PC_BITS-1:0] RESET_PAGE_COUNT = 13'd4096;

    typedef struct packed {
        logic                  found;
        logic [WORD_SHIFT-1:0] bit_idx;
        logic [WORD_BITS-1:0]  onehot;
    } t_find;

endpackage

>>> rtl/bpa_find.sv
module bpa_find (
    input  logic [bpa_pkg::WORD_BITS-1:0] i_word,
    input  logic [bpa_pkg::WORD_BITS-1:0] i_mask,
    output bpa_pkg::t_find                o_find
);

    logic [bpa_pkg::WORD_BITS-1:0]  cand;
    logic [bpa_pkg::WORD_BITS-1:0]  lowest;
    logic [bpa_pkg::WORD_SHIFT-1:0] enc;

    // lowest clear eligible bit, isolated by two's complement
    assign cand   = ~i_word & i_mask;
    assign lowest = cand & (~cand + 1'b1);

    always_comb begin
        enc = '0;
        for (int b = 0; b < bpa_pkg::WORD_SHIFT; b++) begin
            for (int i = 0; i < bpa_pkg::WORD_BITS; i++) begin
                if (((i >> b) & 1) == 1) begin
                    enc[b] = enc[b] | lowest[i];
                end
            end
        end
    end

    assign o_find.found   = |cand;
    assign o_find.bit_idx = enc;
    assign o_find.onehot  = lowest;

endmodule

>>> rtl/bitmap_page_allocator.sv
// free: an item goes S_FCHK, S_FMOD, S_DONE (no S_FMOD for a bad address); allocate goes S_SCAN
//   for each bitmap word read (32 pages per word, up to one wrap), S_ADDR, S_DONE, or only S_DONE
//   if no page is free; S_DONE holds while the output stalls; one item at a time, the next
//   accepted once the result is loaded; reset and page_count writes start a clearing pass over
//   all NUM_PAGES/32 (rounded up) bitmap words during which no item is accepted
module bitmap_page_allocator #(
    parameter int NUM_PAGES  = 4096,
    parameter int PAGE_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [63:0] i_free_address,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_page_address,
    output logic [1:0]  o_status,
    output logic        o_pool_full,
    output logic [12:0] o_free_pages,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

`include "bitmap_page_allocator_macros.svh"

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int DEPTH      = (NUM_PAGES + bpa_pkg::WORD_BITS - 1) / bpa_pkg::WORD_BITS;
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW         = AW + bpa_pkg::WORD_SHIFT;
    localparam int CNT_W      = $clog2(NUM_PAGES + 1);
    localparam int OFFW       = bpa_pkg::ADDR_BITS - PAGE_SHIFT;
    localparam int RESET_LIVE = (NUM_PAGES < int'(bpa_pkg::RESET_PAGE_COUNT)) ?
                                NUM_PAGES : int'(bpa_pkg::RESET_PAGE_COUNT);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_ADDR  = 7'b0001000,
        S_FCHK  = 7'b0010000,
        S_FMOD  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [bpa_pkg::WORD_BITS-1:0] r_mem [DEPTH];
    logic [bpa_pkg::WORD_BITS-1:0] r_rdata;

    logic [63:0]                    r_base;
    logic [bpa_pkg::PC_BITS-1:0]    r_pc;
    logic [CNT_W-1:0]               r_n;
    logic [CNT_W-1:0]               r_free;
    logic                           r_full;
    logic [XW-1:0]                  r_cursor;
    logic [AW-1:0]                  r_clr;
    logic [AW-1:0]                  r_w;
    logic [bpa_pkg::WORD_SHIFT-1:0] r_sbit;
    logic                           r_first;
    logic [XW-1:0]                  r_idx;
    logic [64:0]                    r_off;
    logic [63:0]                    r_res_addr;
    logic [1:0]                     r_res_status;
    logic                           r_ovalid;
    logic [63:0]                    r_oaddr;
    logic [1:0]                     r_ostatus;
    logic                           r_ofull;
    logic [12:0]                    r_ofree;

    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic [bpa_pkg::WORD_BITS-1:0] mem_wdata;
    logic                          mem_re;
    logic [AW-1:0]                 mem_raddr;

    logic        cfg_wr;
    logic [31:0] wr_live;
    logic        accept;
    logic [31:0] n32;
    logic [31:0] n_m1;
    logic [31:0] cur32;
    logic [XW-1:0] start_idx;
    logic [AW-1:0] last_word;
    logic [4:0]    tail;
    logic [bpa_pkg::WORD_BITS-1:0] lo_mask;
    logic [bpa_pkg::WORD_BITS-1:0] hi_mask;
    bpa_pkg::t_find find;
    logic [XW-1:0] found_idx;
    logic [31:0]   nxt32;
    logic [AW-1:0] next_w;
    logic          free_bad;
    logic [XW-1:0] free_idx;
    logic          out_free;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (paddr[3] == bpa_pkg::REG_PAGES) ? {51'd0, r_pc} : r_base;
    assign wr_live = (32'(pwdata[12:0]) < 32'(NUM_PAGES)) ? 32'(pwdata[12:0]) :
                     32'(NUM_PAGES);

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign o_valid = r_ovalid;
    assign o_page_address = r_oaddr;
    assign o_status       = r_ostatus;
    assign o_pool_full    = r_ofull;
    assign o_free_pages   = r_ofree;
    assign out_free       = !r_ovalid || i_ready;

    // region geometry
    assign n32       = 32'(r_n);
    assign n_m1      = n32 - 32'd1;
    assign last_word = n_m1[bpa_pkg::WORD_SHIFT +: AW];
    assign tail      = n32[4:0];
    assign cur32     = 32'(r_cursor);
    assign start_idx = (cur32 < n32) ? r_cursor : '0;

    assign lo_mask = r_first ? ~((bpa_pkg::WORD_BITS'(1) << r_sbit) - 1'b1) : '1;
    assign hi_mask = (r_w != last_word) ? '1 :
                     (tail == 5'd0) ? '1 : ((bpa_pkg::WORD_BITS'(1) << tail) - 1'b1);

    bpa_find u_find (
        .i_word (r_rdata),
        .i_mask (lo_mask & hi_mask),
        .o_find (find)
    );

    assign found_idx = {r_w, find.bit_idx};
    assign nxt32     = 32'(found_idx) + 32'd1;
    assign next_w    = (r_w == last_word) ? '0 : r_w + 1'b1;

    // free address check
    assign free_bad = r_off[64] || (r_off[PAGE_SHIFT-1:0] != '0) ||
                      (r_off[63:PAGE_SHIFT] >= OFFW'(r_n));
    assign free_idx = r_off[PAGE_SHIFT +: XW];

    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_waddr = r_w;
        mem_wdata = r_rdata;
        mem_re    = 1'b0;
        mem_raddr = start_idx[XW-1:bpa_pkg::WORD_SHIFT];
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_command == bpa_pkg::CMD_FREE) begin
                        n_state = S_FCHK;
                    end else if (r_free == '0) begin
                        n_state = S_DONE;
                    end else begin
                        mem_re  = 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (find.found) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_rdata | find.onehot;
                    n_state   = S_ADDR;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = next_w;
                end
            end
            S_ADDR: n_state = S_DONE;
            S_FCHK: begin
                if (free_bad) begin
                    n_state = S_DONE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = free_idx[XW-1:bpa_pkg::WORD_SHIFT];
                    n_state   = S_FMOD;
                end
            end
            S_FMOD: begin
                mem_wdata = r_rdata & ~(bpa_pkg::WORD_BITS'(1) << r_sbit);
                mem_we    = r_rdata[r_sbit];
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
        if (cfg_wr && paddr[3] == bpa_pkg::REG_PAGES) begin
            n_state = S_CLEAR;
        end
    end

    // bitmap memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_base   <= '0;
            r_pc     <= bpa_pkg::RESET_PAGE_COUNT;
            r_n      <= CNT_W'(RESET_LIVE);
            r_free   <= CNT_W'(RESET_LIVE);
            r_full   <= 1'b0;
            r_cursor <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == S_SCAN && find.found) begin
                r_free   <= r_free - 1'b1;
                r_full   <= (r_free == CNT_W'(1));
                r_cursor <= (nxt32 >= n32) ? '0 : XW'(nxt32);
            end
            if (r_state == S_IDLE && accept && i_command == bpa_pkg::CMD_ALLOC &&
                r_free == '0) begin
                r_full <= 1'b1;
            end
            if (r_state == S_FMOD && r_rdata[r_sbit]) begin
                r_free <= r_free + 1'b1;
                r_full <= 1'b0;
            end
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (cfg_wr) begin
                if (paddr[3] == bpa_pkg::REG_PAGES) begin
                    r_pc     <= pwdata[12:0];
                    r_n      <= CNT_W'(wr_live);
                    r_free   <= CNT_W'(wr_live);
                    r_full   <= 1'b0;
                    r_cursor <= '0;
                    r_clr    <= '0;
                end else begin
                    r_base <= pwdata;
                end
            end
        end
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_off        <= {1'b0, i_free_address} - {1'b0, r_base};
                r_res_addr   <= '0;
                r_res_status <= (i_command == bpa_pkg::CMD_ALLOC && r_free == '0) ?
                                bpa_pkg::ST_NOPAGE : bpa_pkg::ST_OK;
                r_w          <= start_idx[XW-1:bpa_pkg::WORD_SHIFT];
                r_sbit       <= start_idx[bpa_pkg::WORD_SHIFT-1:0];
                r_first      <= 1'b1;
            end
            S_SCAN: begin
                r_idx   <= found_idx;
                r_w     <= next_w;
                r_first <= 1'b0;
            end
            S_ADDR: begin
                r_res_addr <= r_base + (64'(r_idx) << PAGE_SHIFT);
            end
            S_FCHK: begin
                r_w    <= free_idx[XW-1:bpa_pkg::WORD_SHIFT];
                r_sbit <= free_idx[bpa_pkg::WORD_SHIFT-1:0];
                if (free_bad) begin
                    r_res_status <= bpa_pkg::ST_BADADDR;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    r_oaddr   <= r_res_addr;
                    r_ostatus <= r_res_status;
                    r_ofull   <= r_full;
                    r_ofree   <= 13'(r_free);
                end
            end
            default: begin
            end
        endcase
    end

    `BPA_ASSERT_NOW(a_free_le_live, i_clk, i_rst_n, 1'b1, r_free <= r_n)
    `BPA_ASSERT_NOW(a_full_means_empty, i_clk, i_rst_n, r_full, r_free == '0)
    `BPA_ASSERT_NOW(a_no_accept_in_clear, i_clk, i_rst_n, r_state == S_CLEAR, !o_ready)
    `BPA_ASSERT_NOW(a_nopage_zero_addr, i_clk, i_rst_n,
        o_valid && o_status == bpa_pkg::ST_NOPAGE, o_page_address == '0)
    `BPA_ASSERT_NEXT(a_one_item_at_a_time, i_clk, i_rst_n, accept, !o_ready)

endmodule
